// File: sv/cpfv_pkg.sv
// shared types, constants and mod-11 helpers for the cpf check digit validator
// no dependencies; imported by every module of the block
package cpfv_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  localparam logic [3:0] CPF_DIGITS     = 4'd11;
  localparam logic [3:0] COUNT_SAT      = 4'd12;
  localparam logic [3:0] FIRST_CHK_POS  = 4'd9;
  localparam logic [3:0] SECOND_CHK_POS = 4'd10;
  localparam logic [3:0] FIRST_WT_BASE  = 4'd10;
  localparam logic [3:0] SECOND_WT_BASE = 4'd11;
  localparam logic [4:0] MOD_ELEVEN     = 5'd11;
  localparam logic [3:0] LOW_REM_LIMIT  = 4'd2;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } item_t;

  // (digit * weight) mod 11 for every 4-bit digit/weight pair, 4 bits per entry
  function automatic logic [1023:0] build_mul_mod_tab();
    logic [1023:0] tab;
    tab = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i*4 +: 4] = 4'(((i / 16) * (i % 16)) % 11);
    end
    return tab;
  endfunction

  localparam logic [1023:0] MUL_MOD_TAB = build_mul_mod_tab();

  function automatic logic [3:0] mul_mod11(logic [3:0] d, logic [3:0] w);
    logic [9:0] idx;
    idx = {d, w, 2'b00};
    return MUL_MOD_TAB[idx +: 4];
  endfunction

  // both operands already below 11, so one conditional subtract suffices
  function automatic logic [3:0] add_mod11(logic [3:0] a, logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_ELEVEN) begin
      s = s - MOD_ELEVEN;
    end
    return s[3:0];
  endfunction

  function automatic logic [3:0] expected_check(logic [3:0] r);
    logic [3:0] c;
    if (r < LOW_REM_LIMIT) begin
      c = 4'd0;
    end else begin
      c = SECOND_WT_BASE - r;
    end
    return c;
  endfunction

endpackage

// File: sv/cpfv_front.sv
// front end: accepts characters, decodes ascii digits, drops items with no effect
// depends on cpfv_pkg (item_t, ascii constants)
module cpfv_front import cpfv_pkg::*; (
  input  logic [7:0] ch_i,
  input  logic       has_char_i,
  input  logic       last_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o
);

  logic is_digit;

  assign is_digit = has_char_i && (ch_i >= ASCII_ZERO) && (ch_i <= ASCII_NINE);

  assign q_item_o.is_digit = is_digit;
  // ascii '0'..'9' carry their value in the low nibble
  assign q_item_o.digit    = ch_i[3:0];
  assign q_item_o.last     = last_i;

  assign in_stall_o = q_full_i;
  // a non-digit that does not end the string changes nothing
  assign q_push_o   = in_valid_i && !q_full_i && (is_digit || last_i);

endmodule

// File: sv/cpfv_fifo.sv
// short register queue between front and back ends
// depends on cpfv_pkg (item_t, FIFO_DEPTH)
module cpfv_fifo import cpfv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t head_o,
  output logic  empty_o
);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: sv/cpfv_back.sv
// back end: per-digit accumulate of mod-11 residues, final check, output register
// depends on cpfv_pkg (item_t, mod-11 helpers)
module cpfv_back import cpfv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  item_t q_head_i,
  output logic  q_pop_o,
  output logic  valid_res_o,
  output logic  out_valid_o,
  input  logic  out_stall_i
);

  logic [3:0] count_q, count_d;
  logic [3:0] rem1_q, rem1_d;
  logic [3:0] rem2_q, rem2_d;
  logic [3:0] lead_q, lead_d;
  logic       same_q, same_d;
  logic [3:0] chk1_q, chk1_d;
  logic [3:0] chk2_q, chk2_d;
  logic       out_valid_q, out_valid_d;
  logic       res_q, res_d;

  logic       out_free;
  logic [3:0] d;
  logic [3:0] pos;
  logic [3:0] n_count, n_rem1, n_rem2, n_lead, n_chk1, n_chk2;
  logic       n_same;
  logic       ok;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = !q_empty_i && (!q_head_i.last || out_free);
  assign d        = q_head_i.digit;
  assign pos      = count_q;

  // state after taking the head item's digit, if it carries one
  always_comb begin
    n_count = count_q;
    n_rem1  = rem1_q;
    n_rem2  = rem2_q;
    n_lead  = lead_q;
    n_same  = same_q;
    n_chk1  = chk1_q;
    n_chk2  = chk2_q;
    if (q_head_i.is_digit) begin
      if (pos == '0) begin
        n_lead = d;
      end else if (d != lead_q) begin
        n_same = 1'b0;
      end
      if (pos < FIRST_CHK_POS) begin
        n_rem1 = add_mod11(rem1_q, mul_mod11(d, FIRST_WT_BASE - pos));
      end
      if (pos < SECOND_CHK_POS) begin
        n_rem2 = add_mod11(rem2_q, mul_mod11(d, SECOND_WT_BASE - pos));
      end
      if (pos == FIRST_CHK_POS) begin
        n_chk1 = d;
      end
      if (pos == SECOND_CHK_POS) begin
        n_chk2 = d;
      end
      if (count_q < COUNT_SAT) begin
        n_count = count_q + 4'd1;
      end
    end
  end

  assign ok = (n_count == CPF_DIGITS) && !n_same &&
              (expected_check(n_rem1) == n_chk1) &&
              (expected_check(n_rem2) == n_chk2);

  always_comb begin
    count_d     = count_q;
    rem1_d      = rem1_q;
    rem2_d      = rem2_q;
    lead_d      = lead_q;
    same_d      = same_q;
    chk1_d      = chk1_q;
    chk2_d      = chk2_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    if (q_pop_o) begin
      if (q_head_i.last) begin
        out_valid_d = 1'b1;
        res_d       = ok;
        // string done, start the next one clean
        count_d     = '0;
        rem1_d      = '0;
        rem2_d      = '0;
        lead_d      = '0;
        same_d      = 1'b1;
        chk1_d      = '0;
        chk2_d      = '0;
      end else begin
        count_d = n_count;
        rem1_d  = n_rem1;
        rem2_d  = n_rem2;
        lead_d  = n_lead;
        same_d  = n_same;
        chk1_d  = n_chk1;
        chk2_d  = n_chk2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem1_q      <= '0;
      rem2_q      <= '0;
      lead_q      <= '0;
      same_q      <= 1'b1;
      chk1_q      <= '0;
      chk2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rem1_q      <= rem1_d;
      rem2_q      <= rem2_d;
      lead_q      <= lead_d;
      same_q      <= same_d;
      chk1_q      <= chk1_d;
      chk2_q      <= chk2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

endmodule

// File: sv/cpf_check_digit_validator_top.sv
// cpf check digit validator: takes a string one character per transfer and
// returns one pass/fail bit for each string.
// input channel: ch_i, has_char_i, last_i with in_valid_i / in_stall_o.
//   characters other than ascii '0'..'9' are ignored; has_char_i low means the
//   transfer carries no character (an empty string is one such transfer with last_i).
// output channel: valid_res_o with out_valid_o / out_stall_i, one transfer per
//   string, issued for the transfer that carries last_i.
// throughput: one character per cycle sustained; the front end decodes and pushes
//   into a 4-entry queue, the back end pops one entry per cycle and folds the digit
//   into two mod-11 residues through a constant table, unless a held result stalls.
// result path: the last_i item is queued, then popped into the output register.
// receiver stall: the result is held in the output register; characters keep
//   flowing until the back end meets the next last item and the queue fills,
//   then in_stall_o rises.
// reset: rst_ni low clears queue, string state and output valid.
// depends on cpfv_pkg, cpfv_front, cpfv_fifo, cpfv_back
module cpf_check_digit_validator_top import cpfv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic       has_char_i,
  input  logic       last_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       valid_res_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_item, q_head;

  cpfv_front u_front (
    .ch_i       (ch_i),
    .has_char_i (has_char_i),
    .last_i     (last_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  cpfv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  cpfv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .valid_res_o (valid_res_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: verif/cpf_check_digit_validator_top_tb.sv
// self-checking testbench for cpf_check_digit_validator_top: streams character strings,
// predicts the mod-11 verdict of each one and checks it against every output transfer
// depends only on the rtl of the block (no package types needed at the ports)
`timescale 1ns / 100ps

module cpf_check_digit_validator_top_tb;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam int         CPF_LEN    = 11;
  localparam int         CNT_SAT    = 12;
  localparam int         LONG_HOLD  = 300;
  localparam int         PHASE_CHARS = 300;

  typedef struct {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } char_xfer_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic [7:0] ch_i        = '0;
  logic       has_char_i  = 1'b0;
  logic       last_i      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       valid_res_o;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;

  cpf_check_digit_validator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (ch_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .valid_res_o (valid_res_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  char_xfer_t pending_q[$];
  char_xfer_t str_buf[$];
  char_xfer_t drv_next;
  bit         verdict_q[$];
  logic [3:0] cpf_dg[CPF_LEN];

  int snd_idle_pct = 19;
  int rcv_idle_pct = 88;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  int long_hold_cnt  = 0;

  int chars_queued  = 0;
  int chars_sent    = 0;
  int strings_sent  = 0;
  int results_seen  = 0;
  int valid_seen    = 0;
  int err_cnt       = 0;

  // predictor state for the string in flight
  logic [3:0] digit_cnt;
  logic [8:0] wsum_first;
  logic [9:0] wsum_second;
  logic [3:0] lead_dig;
  logic       digits_equal;
  logic [3:0] got_check_one;
  logic [3:0] got_check_two;

  task automatic clear_cpf_state();
    digit_cnt     = '0;
    wsum_first    = '0;
    wsum_second   = '0;
    lead_dig      = '0;
    digits_equal  = 1'b1;
    got_check_one = '0;
    got_check_two = '0;
  endtask

  function automatic logic [3:0] mod11_check_digit(input int unsigned s);
    int unsigned r;
    r = s % 11;
    return (r < 2) ? 4'd0 : 4'(11 - r);
  endfunction

  // fold one accepted transfer into the running sums, queue the verdict on last
  task automatic cpf_fold_char(input logic [7:0] c, input logic h, input logic l);
    logic [3:0] d;
    int         pos;
    bit         ok;
    if (h && c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d   = 4'(c - CHAR_ZERO);
      pos = int'(digit_cnt);
      if (pos == 0) begin
        lead_dig = d;
      end else if (d != lead_dig) begin
        digits_equal = 1'b0;
      end
      if (pos < 9) begin
        wsum_first = 9'(int'(wsum_first) + int'(d) * (10 - pos));
      end
      if (pos < 10) begin
        wsum_second = 10'(int'(wsum_second) + int'(d) * (11 - pos));
      end
      if (pos == 9) begin
        got_check_one = d;
      end
      if (pos == 10) begin
        got_check_two = d;
      end
      if (pos < CNT_SAT) begin
        digit_cnt = digit_cnt + 4'd1;
      end
    end
    if (l) begin
      ok = (int'(digit_cnt) == CPF_LEN) && !digits_equal &&
           (mod11_check_digit(wsum_first) == got_check_one) &&
           (mod11_check_digit(wsum_second) == got_check_two);
      verdict_q.push_back(ok);
      strings_sent++;
      clear_cpf_state();
    end
  endtask

  // driver: payload holds while stalled, a new transfer may follow an accepted one directly
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= '0;
      has_char_i <= 1'b0;
      last_i     <= 1'b0;
      clear_cpf_state();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cpf_fold_char(ch_i, has_char_i, last_i);
        chars_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          drv_next = pending_q.pop_front();
          ch_i       <= drv_next.ch;
          has_char_i <= drv_next.has_char;
          last_i     <= drv_next.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and drives the receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (valid_res_o === 1'b1) begin
          valid_seen++;
        end
        if (verdict_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %b",
                   $time, valid_res_o);
          err_cnt++;
        end else if (valid_res_o !== verdict_q[0]) begin
          $display("%0t: valid_res mismatch, expected %b, actual %b",
                   $time, verdict_q[0], valid_res_o);
          err_cnt++;
          void'(verdict_q.pop_front());
        end else begin
          void'(verdict_q.pop_front());
        end
      end
      if (long_hold_req && !long_hold_done) begin
        out_stall_i <= 1'b1;
        long_hold_cnt++;
        if (long_hold_cnt == LONG_HOLD) begin
          long_hold_done = 1'b1;
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  task automatic put_char(input logic [7:0] c, input logic h);
    char_xfer_t x;
    x.ch       = c;
    x.has_char = h;
    x.last     = 1'b0;
    str_buf.push_back(x);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i], 1'b1);
    end
  endtask

  // marks the final transfer; an empty buffer becomes a single no-character transfer
  task automatic close_string();
    if (str_buf.size() == 0) begin
      put_char(8'($urandom_range(255)), 1'b0);
    end
    str_buf[str_buf.size() - 1].last = 1'b1;
    chars_queued += str_buf.size();
    foreach (str_buf[i]) begin
      pending_q.push_back(str_buf[i]);
    end
    str_buf.delete();
  endtask

  // non-digit byte or a transfer without a character
  task automatic put_noise();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ($urandom_range(2) == 0) begin
      put_char(c, 1'b0);
    end else begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        c = c | 8'h80;
      end
      put_char(c, 1'b1);
    end
  endtask

  task automatic make_cpf();
    int s1;
    int s2;
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < 9; i++) begin
      cpf_dg[i] = 4'($urandom_range(9));
      s1 += int'(cpf_dg[i]) * (10 - i);
      s2 += int'(cpf_dg[i]) * (11 - i);
    end
    cpf_dg[9]  = mod11_check_digit(s1);
    s2        += int'(cpf_dg[9]) * 2;
    cpf_dg[10] = mod11_check_digit(s2);
  endtask

  task automatic add_random_string();
    int kind;
    int n;
    int k;
    bit fmt;
    logic [3:0] d;
    kind = $urandom_range(99);
    if (kind < 55) begin
      // well-formed number, some with a damaged digit
      make_cpf();
      if (kind >= 40) begin
        k = $urandom_range(CPF_LEN - 1);
        cpf_dg[k] = 4'((int'(cpf_dg[k]) + $urandom_range(1, 9)) % 10);
      end
      fmt = $urandom_range(1);
      for (int i = 0; i < CPF_LEN; i++) begin
        put_char(CHAR_ZERO + 8'(cpf_dg[i]), 1'b1);
        if (fmt && (i == 2 || i == 5)) put_char(CHAR_DOT, 1'b1);
        if (fmt && i == 8) put_char(CHAR_DASH, 1'b1);
      end
    end else if (kind < 63) begin
      d = 4'($urandom_range(9));
      for (int i = 0; i < CPF_LEN; i++) begin
        put_char(CHAR_ZERO + 8'(d), 1'b1);
      end
    end else if (kind < 73) begin
      n = $urandom_range(1) ? $urandom_range(1, 10) : $urandom_range(12, 15);
      for (int i = 0; i < n; i++) begin
        put_char(CHAR_ZERO + 8'($urandom_range(9)), 1'b1);
      end
    end else if (kind < 83) begin
      // number with junk mixed in, sometimes ended by a transfer without a character
      make_cpf();
      for (int i = 0; i < CPF_LEN; i++) begin
        if ($urandom_range(9) < 3) put_noise();
        put_char(CHAR_ZERO + 8'(cpf_dg[i]), 1'b1);
      end
      if ($urandom_range(1)) put_char(8'($urandom_range(255)), 1'b0);
    end else if (kind < 93) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        put_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    close_string();
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_random(input int n_chars);
    int goal;
    goal = chars_queued + n_chars;
    while (chars_queued < goal) begin
      add_random_string();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty string, lone no-character transfer, byte extremes, a known number
    close_string();
    put_char(CHAR_ZERO + 8'd5, 1'b0);
    close_string();
    put_char(8'h00, 1'b1);
    put_char(CHAR_ZERO - 8'd1, 1'b1);
    put_char(CHAR_NINE + 8'd1, 1'b1);
    put_char(8'hff, 1'b1);
    close_string();
    put_text("52998224725");
    put_char(8'h00, 1'b0);
    close_string();
    run_random(PHASE_CHARS);
    wait_drained();

    snd_idle_pct = 88;
    rcv_idle_pct = 19;
    run_random(PHASE_CHARS);
    wait_drained();

    // no idling; one long receiver hold-off while input keeps coming
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    long_hold_req = 1'b1;
    run_random(PHASE_CHARS);
    wait_drained();

    repeat (8) @(negedge clk_i);
    $display("covered %0d character transfers in %0d strings, %0d verdicts (%0d valid)",
             chars_sent, strings_sent, results_seen, valid_seen);
    $display("receiver held off for %0d cycles in one stretch with input still offered",
             long_hold_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/cpfv_pkg.sv
sv/cpfv_front.sv
sv/cpfv_fifo.sv
sv/cpfv_back.sv
sv/cpf_check_digit_validator_top.sv
verif/cpf_check_digit_validator_top_tb.sv
